FILE: rtl/core/abmx_pkg.sv
// Shared constants, codes and item types of the audio mix bus.
// No dependencies; every other file of the block but abmx_ram uses this package.
package abmx_pkg;

   // Bus geometry
   localparam int NUM_CHANNELS = 128;
   localparam int BLOCK_LEN    = 64;
   localparam int SAMPLE_BITS  = 24;
   localparam int CH_BITS      = $clog2(NUM_CHANNELS);
   localparam int IDX_BITS     = $clog2(BLOCK_LEN);
   localparam int ADDR_BITS    = CH_BITS + IDX_BITS;
   localparam int BUS_DEPTH    = NUM_CHANNELS * BLOCK_LEN;

   // Gains are Q1.16, one is 2^16
   localparam int GAIN_BITS = 17;
   localparam int GAIN_FRAC = 16;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC);

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Action codes
   localparam int ACTION_BITS = 3;
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_READ   = 3'd0,
      ACT_ACCUM  = 3'd1,
      ACT_REPL   = 3'd2,
      ACT_XFADE  = 3'd3,
      ACT_NEWBLK = 3'd4
   } action_type;

   // One classified item as it travels through the work queue
   typedef struct packed {
      action_type                    op;
      logic [CH_BITS-1:0]            channel;
      logic [IDX_BITS-1:0]           sample_index;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [GAIN_BITS-1:0]          gain;
      logic                          last;
   } work_type;

endpackage

FILE: rtl/core/abmx_if.sv
// Request and response channel interfaces of the audio mix bus.
// Depends on abmx_pkg for field widths.
interface abmx_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [abmx_pkg::ACTION_BITS-1:0]        action;
   logic [abmx_pkg::CH_BITS-1:0]            channel;
   logic [abmx_pkg::IDX_BITS-1:0]           sample_index;
   logic signed [abmx_pkg::SAMPLE_BITS-1:0] sample_in;
   logic [abmx_pkg::GAIN_BITS-1:0]          gain_start;
   logic [abmx_pkg::GAIN_BITS-1:0]          gain_end;
   logic                                    block_last;

   modport source (output valid, action, channel, sample_index, sample_in,
                   gain_start, gain_end, block_last, input ready);
   modport sink (input valid, action, channel, sample_index, sample_in,
                 gain_start, gain_end, block_last, output ready);
endinterface

interface abmx_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [abmx_pkg::SAMPLE_BITS-1:0] sample_out;
   logic                                    channel_was_written;

   modport source (output valid, sample_out, channel_was_written, input ready);
   modport sink (input valid, sample_out, channel_was_written, output ready);
endinterface

FILE: rtl/core/audio_bus_mix_crossfade.sv
// Audio mix bus: 128 channels x 64 samples of Q1.23 with accumulate, replace,
// crossfade and read, plus per-channel written flags cleared by new block.
// Throughput: the front end takes one request transfer per cycle, while the
// queue has room, into a four-entry work queue. The back end then steps each
// accumulate, replace or crossfade through queue pop with bus RAM read, data
// return, gain multiply and write-back, a read through queue pop with bus RAM
// read and data return, and a new block through the queue pop alone; this
// single sequencer around the one-read, one-write bus RAM takes no new item
// until it is through with the last one. A read leaves the queue only once
// the previous response has been transferred. Unknown actions and crossfades
// with both gains at zero are dropped in the front end and cost no back-end
// time. The bus RAM is not cleared after reset; the written flags are.
// Depends on abmx_pkg, abmx_if, abmx_front, abmx_queue and abmx_back.
module audio_bus_mix_crossfade (
   input  logic       clock,
   input  logic       reset,
   abmx_req_if.sink   req_chan,
   abmx_rsp_if.source rsp_chan
);

   logic               push_valid, push_ready;
   abmx_pkg::work_type push_data;
   logic               pop_valid, pop_ready;
   abmx_pkg::work_type pop_data;

   abmx_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   abmx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   abmx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: rtl/core/abmx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No package dependencies.
module abmx_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8192,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/abmx_front.sv
// Front end: takes request transfers, decodes the action and works out
// the crossfade gain for the sample position. Depends on abmx_pkg, abmx_if.
module abmx_front (
   abmx_req_if.sink           req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output abmx_pkg::work_type push_data
);

   localparam int WEIGHT_BITS = abmx_pkg::IDX_BITS + 1;
   localparam int MIX_BITS    = abmx_pkg::GAIN_BITS + WEIGHT_BITS;

   logic [abmx_pkg::GAIN_BITS-1:0] g_start;
   logic [abmx_pkg::GAIN_BITS-1:0] g_end;
   logic [WEIGHT_BITS-1:0]         w_start;
   logic [WEIGHT_BITS-1:0]         w_end;
   logic [MIX_BITS-1:0]            mix;
   logic                           known_op;
   logic                           silent_fade;

   // Gains clamp at one
   assign g_start = (req_chan.gain_start > abmx_pkg::GAIN_ONE) ?
                    abmx_pkg::GAIN_ONE : req_chan.gain_start;
   assign g_end   = (req_chan.gain_end > abmx_pkg::GAIN_ONE) ?
                    abmx_pkg::GAIN_ONE : req_chan.gain_end;

   // Linear ramp across the block, then divide by the block length
   assign w_end   = WEIGHT_BITS'(req_chan.sample_index);
   assign w_start = WEIGHT_BITS'(abmx_pkg::BLOCK_LEN) - w_end;
   assign mix     = MIX_BITS'(g_start) * MIX_BITS'(w_start) +
                    MIX_BITS'(g_end) * MIX_BITS'(w_end);

   // Unknown actions and a crossfade with both gains at zero leave no trace
   assign known_op    = req_chan.action <= abmx_pkg::ACTION_BITS'(abmx_pkg::ACT_NEWBLK);
   assign silent_fade = (req_chan.action == abmx_pkg::ACT_XFADE) &&
                        (g_start == '0) && (g_end == '0);

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid && known_op && !silent_fade;

   always_comb begin
      push_data.op           = abmx_pkg::action_type'(req_chan.action);
      push_data.channel      = req_chan.channel;
      push_data.sample_index = req_chan.sample_index;
      push_data.sample_in    = req_chan.sample_in;
      push_data.gain         = abmx_pkg::GAIN_BITS'(mix / abmx_pkg::BLOCK_LEN);
      push_data.last         = req_chan.block_last;
   end

endmodule

FILE: rtl/core/abmx_queue.sv
// Short work queue between front end and back end.
// Depends on abmx_pkg for the entry type and depth.
module abmx_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  abmx_pkg::work_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output abmx_pkg::work_type pop_data
);

   abmx_pkg::work_type              entries_ff [abmx_pkg::QUEUE_DEPTH];
   logic [abmx_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [abmx_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [abmx_pkg::QPTR_BITS:0]    count_ff, count_in;
   logic                            push, pop;

   assign push_ready = count_ff != (abmx_pkg::QPTR_BITS+1)'(abmx_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/abmx_back.sv
// Back end: runs writes via bus RAM read, multiply and write-back,
// reads via RAM read only; keeps written flags and response register.
// Depends on abmx_pkg, abmx_if and abmx_ram.
module abmx_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  abmx_pkg::work_type pop_data,
   abmx_rsp_if.source         rsp_chan
);

   localparam int SB        = abmx_pkg::SAMPLE_BITS;
   localparam int DIFF_BITS = SB + 1;
   localparam int PROD_BITS = abmx_pkg::GAIN_BITS + 1 + DIFF_BITS;
   localparam int RND_BITS  = PROD_BITS + 1 - abmx_pkg::GAIN_FRAC;
   localparam int WIDE_BITS = RND_BITS + 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_MUL   = 4'b0100,
      ST_WRITE = 4'b1000
   } back_state_type;

   // Clamp a wide signed value into the sample range
   function automatic logic signed [SB-1:0] sat_sample(
      input logic signed [WIDE_BITS-1:0] v
   );
      logic [WIDE_BITS-SB:0] top;
      logic signed [SB-1:0]  r;
      top = v[WIDE_BITS-1:SB-1];
      if ((top == '0) || (top == '1)) begin
         r = v[SB-1:0];
      end else if (v[WIDE_BITS-1]) begin
         r = {1'b1, {(SB-1){1'b0}}};
      end else begin
         r = {1'b0, {(SB-1){1'b1}}};
      end
      return r;
   endfunction

   back_state_type                  state_ff, state_in;
   abmx_pkg::work_type              cur_ff, cur_in;
   logic [abmx_pkg::NUM_CHANNELS-1:0] flags_ff, flags_in;
   logic signed [SB-1:0]            base_ff, base_in;
   logic signed [DIFF_BITS-1:0]     diff_ff, diff_in;
   logic signed [PROD_BITS-1:0]     prod_ff, prod_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]            rsp_sample_ff, rsp_sample_in;
   logic                            rsp_written_ff, rsp_written_in;

   logic                            pop;
   logic                            ram_rd_en;
   logic [abmx_pkg::ADDR_BITS-1:0]  ram_rd_addr;
   logic [SB-1:0]                   ram_rd_data;
   logic                            ram_wr_en;
   logic [abmx_pkg::ADDR_BITS-1:0]  ram_wr_addr;
   logic signed [SB-1:0]            new_sample;
   logic                            cur_written;
   logic signed [SB-1:0]            old_sample;
   logic signed [PROD_BITS:0]       rnd_sum;
   logic signed [RND_BITS-1:0]      rnd;
   logic signed [WIDE_BITS-1:0]     fade_sum;
   logic signed [WIDE_BITS-1:0]     acc_sum;

   // A read waits in the queue until the response register is free
   assign pop_ready = (state_ff == ST_IDLE) &&
                      ((pop_data.op != abmx_pkg::ACT_READ) || !rsp_valid_ff);
   assign pop       = pop_valid && pop_ready;

   // Bus RAM access
   assign ram_rd_en   = pop && (pop_data.op != abmx_pkg::ACT_NEWBLK);
   assign ram_rd_addr = {pop_data.channel, pop_data.sample_index};
   assign ram_wr_en   = state_ff == ST_WRITE;
   assign ram_wr_addr = {cur_ff.channel, cur_ff.sample_index};

   abmx_ram #(
      .WIDTH (SB),
      .DEPTH (abmx_pkg::BUS_DEPTH)
   ) u_bus_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (new_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Old value counts only once a write marked last flags the channel
   assign cur_written = flags_ff[cur_ff.channel];
   assign old_sample  = cur_written ? $signed(ram_rd_data) : '0;

   // Write-back arithmetic: round half up, then add and saturate
   assign rnd_sum  = (PROD_BITS+1)'(prod_ff) +
                     (PROD_BITS+1)'(1 << (abmx_pkg::GAIN_FRAC - 1));
   assign rnd      = rnd_sum[PROD_BITS:abmx_pkg::GAIN_FRAC];
   assign fade_sum = WIDE_BITS'(base_ff) + WIDE_BITS'(rnd);
   assign acc_sum  = WIDE_BITS'(base_ff) + WIDE_BITS'(cur_ff.sample_in);

   always_comb begin
      case (cur_ff.op)
         abmx_pkg::ACT_ACCUM: new_sample = sat_sample(acc_sum);
         abmx_pkg::ACT_XFADE: new_sample = sat_sample(fade_sum);
         default:             new_sample = cur_ff.sample_in;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      flags_in       = flags_ff;
      base_in        = base_ff;
      diff_in        = diff_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_written_in = rsp_written_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_in = pop_data;
               if (pop_data.op == abmx_pkg::ACT_NEWBLK) begin
                  flags_in = '0;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (cur_ff.op == abmx_pkg::ACT_READ) begin
               rsp_valid_in   = 1'b1;
               rsp_sample_in  = old_sample;
               rsp_written_in = cur_written;
               state_in       = ST_IDLE;
            end else begin
               base_in  = old_sample;
               diff_in  = DIFF_BITS'(cur_ff.sample_in) - DIFF_BITS'(old_sample);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'($signed({1'b0, cur_ff.gain})) *
                       PROD_BITS'(diff_ff);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (cur_ff.last) begin
               flags_in[cur_ff.channel] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      base_ff        <= base_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_written_ff <= rsp_written_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.sample_out          = rsp_sample_ff;
   assign rsp_chan.channel_was_written = rsp_written_ff;

   // A new response only comes out of the load step of a read
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff == ST_LOAD && cur_ff.op == abmx_pkg::ACT_READ))
      else $error("response raised outside a read");

   // An unwritten channel always reads back as silence
   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_written_ff) |-> (rsp_sample_ff == '0))
      else $error("unwritten channel returned nonzero sample");

   // New block clears every written flag
   a_newblk_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_data.op == abmx_pkg::ACT_NEWBLK) |=> (flags_ff == '0))
      else $error("written flags not cleared on new block");

   // Nothing leaves the queue while an item is in flight
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !pop)
      else $error("queue popped while back end busy");

endmodule
